// ----- hdl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the line pixel rasterizer
// Holds the coordinate widths, command codes, step direction codes and the
// per-axis setup and advance functions.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_BITS = 10;
    localparam int ERR_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 16;
    localparam int DIR_BITS   = 2;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ERR_BITS-1:0]   err_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [DIR_BITS-1:0]   dir_t;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Step direction codes.
    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd3;

    // One command as held in the input register.
    typedef struct packed {
        logic   cmd;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
        color_t color;
    } in_item_t;

    // Distance and direction of one axis.
    typedef struct packed {
        coord_t span;
        dir_t   dir;
    } axis_setup_t;

    // Error and position of one axis after a pixel.
    typedef struct packed {
        err_t   err;
        coord_t pos;
    } axis_state_t;

    // Absolute distance and direction code from one endpoint to the other.
    function automatic axis_setup_t axis_setup(input coord_t from, input coord_t to);
        axis_setup_t res;
        if (to > from)
        begin
            res.span = to - from;
            res.dir  = DIR_UP;
        end
        else if (to == from)
        begin
            res.span = '0;
            res.dir  = DIR_NONE;
        end
        else
        begin
            res.span = from - to;
            res.dir  = DIR_DOWN;
        end
        return res;
    endfunction

    // Accumulate the axis distance; when the error passes the major distance,
    // take it back down and move the coordinate one step.
    function automatic axis_state_t axis_advance(input err_t err, input coord_t span,
                                                 input dir_t dir, input coord_t major,
                                                 input coord_t pos);
        axis_state_t res;
        err_t        sum;
        sum     = err + {1'b0, span};
        res.err = sum;
        res.pos = pos;
        if (sum > {1'b0, major})
        begin
            res.err = sum - {1'b0, major};
            case (dir)
                DIR_UP:   res.pos = pos + coord_t'(1);
                DIR_DOWN: res.pos = pos - coord_t'(1);
                default:  res.pos = pos;
            endcase
        end
        return res;
    endfunction

endpackage

// ----- hdl/lpr_if.sv -----
// ----------------------------------------------------------------------------
// lpr_cmd_if / lpr_pix_if: valid/ready channels of the rasterizer
// The command channel carries load and pixel commands; the pixel channel
// carries the emitted pixels.
// ----------------------------------------------------------------------------
interface lpr_cmd_if;
    import lpr_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t pixel_color_in;

    modport source (output valid, cmd, x_start, y_start, x_end, y_end, pixel_color_in,
                    input ready);
    modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, pixel_color_in,
                    output ready);
endinterface

interface lpr_pix_if;
    import lpr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ----- hdl/line_pixel_rasterizer.sv -----
// ----------------------------------------------------------------------------
// line_pixel_rasterizer: error-accumulating line rasterizer
// Turns line load commands and pixel ticks into a stream of line pixels.
// ----------------------------------------------------------------------------
// Usage:
// The cmds channel takes commands. A load command (cmd = 0) sets up a new
// line from its endpoints and color and gives no pixel; it replaces any line
// still in progress. Each pixel command (cmd = 1) on an active line gives one
// transaction on the pixels channel; a line gives its major-axis distance
// plus two pixels, and the final one carries last. Pixel commands with no
// line active are consumed and give nothing.
// A pixel command passes through the input register and then the result
// register before it shows on the pixels channel. Throughput is one command
// per cycle while the receiver does not stall; the line state is updated
// between the input register and the result register.
// Reset clears the line state, so the block starts idle with both channels
// empty. When the receiver stalls, the pending pixel holds in the result
// register, one more command waits in the input register, and cmds.ready
// drops until the receiver takes the pixel.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer
(
    input  logic       clk,
    input  logic       rst_n,
    lpr_cmd_if.sink    cmds,
    lpr_pix_if.source  pixels
);
    import lpr_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     advance;

    // Input register.
    lpr_input_stage u_input_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmds       (cmds),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Line state and result register.
    lpr_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .pixels     (pixels)
    );

endmodule

// ----- hdl/lpr_input_stage.sv -----
// ----------------------------------------------------------------------------
// lpr_input_stage: input register of the rasterizer
// Captures one command transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lpr_input_stage
(
    input  logic             clk,
    input  logic             rst_n,
    lpr_cmd_if.sink          cmds,
    input  logic             advance,
    output logic             item_valid,
    output lpr_pkg::in_item_t item
);
    import lpr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register is free when empty or when the core takes it this cycle.
    assign cmds.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmds.ready)
        begin
            valid_next = cmds.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmds.valid && cmds.ready)
        begin
            item_reg.cmd     <= cmds.cmd;
            item_reg.x_start <= cmds.x_start;
            item_reg.y_start <= cmds.y_start;
            item_reg.x_end   <= cmds.x_end;
            item_reg.y_end   <= cmds.y_end;
            item_reg.color   <= cmds.pixel_color_in;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hdl/lpr_core.sv -----
// ----------------------------------------------------------------------------
// lpr_core: line state, error accumulators and result register
// Applies one command per cycle (unless stalled) to the line state and loads
// the result register with the current pixel on each active-line pixel command.
// ----------------------------------------------------------------------------
module lpr_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  lpr_pkg::in_item_t item,
    output logic              advance,
    lpr_pix_if.source         pixels
);
    import lpr_pkg::*;

    // Line state.
    coord_t col_reg, col_next;
    coord_t row_reg, row_next;
    err_t   col_err_reg, col_err_next;
    err_t   row_err_reg, row_err_next;
    coord_t abs_dx_reg, abs_dx_next;
    coord_t abs_dy_reg, abs_dy_next;
    dir_t   col_dir_reg, col_dir_next;
    dir_t   row_dir_reg, row_dir_next;
    coord_t major_reg, major_next;
    err_t   left_reg, left_next;
    color_t color_reg, color_next;
    logic   active_reg, active_next;

    // Result register.
    logic   out_valid_reg, out_valid_next;
    coord_t out_x_reg, out_x_next;
    coord_t out_y_reg, out_y_next;
    color_t out_color_reg, out_color_next;
    logic   out_last_reg, out_last_next;

    axis_setup_t set_x;
    axis_setup_t set_y;
    axis_state_t adv_x;
    axis_state_t adv_y;
    coord_t      major_new;
    logic        fire;

    // The result register is free when empty or being drained.
    assign advance = !out_valid_reg || pixels.ready;
    assign fire    = item_valid && advance;

    always_comb
    begin
        set_x     = axis_setup(item.x_start, item.x_end);
        set_y     = axis_setup(item.y_start, item.y_end);
        major_new = (set_x.span > set_y.span) ? set_x.span : set_y.span;
        adv_x     = axis_advance(col_err_reg, abs_dx_reg, col_dir_reg, major_reg, col_reg);
        adv_y     = axis_advance(row_err_reg, abs_dy_reg, row_dir_reg, major_reg, row_reg);
    end

    // Next-state logic for one command.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_err_next   = col_err_reg;
        row_err_next   = row_err_reg;
        abs_dx_next    = abs_dx_reg;
        abs_dy_next    = abs_dy_reg;
        col_dir_next   = col_dir_reg;
        row_dir_next   = row_dir_reg;
        major_next     = major_reg;
        left_next      = left_reg;
        color_next     = color_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !pixels.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        if (fire)
        begin
            if (item.cmd == CMD_LOAD)
            begin
                abs_dx_next  = set_x.span;
                abs_dy_next  = set_y.span;
                col_dir_next = set_x.dir;
                row_dir_next = set_y.dir;
                major_next   = major_new;
                col_next     = item.x_start;
                row_next     = item.y_start;
                col_err_next = '0;
                row_err_next = '0;
                left_next    = {1'b0, major_new} + err_t'(2);
                color_next   = item.color;
                active_next  = 1'b1;
            end
            else if (active_reg)
            begin
                // Emit the current pixel, then step both accumulators.
                out_valid_next = 1'b1;
                out_x_next     = col_reg;
                out_y_next     = row_reg;
                out_color_next = color_reg;
                out_last_next  = (left_reg == err_t'(1));
                col_err_next   = adv_x.err;
                col_next       = adv_x.pos;
                row_err_next   = adv_y.err;
                row_next       = adv_y.pos;
                left_next      = left_reg - err_t'(1);
                if (left_next == '0)
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            col_err_reg   <= '0;
            row_err_reg   <= '0;
            abs_dx_reg    <= '0;
            abs_dy_reg    <= '0;
            col_dir_reg   <= DIR_NONE;
            row_dir_reg   <= DIR_NONE;
            major_reg     <= '0;
            left_reg      <= '0;
            color_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_err_reg   <= col_err_next;
            row_err_reg   <= row_err_next;
            abs_dx_reg    <= abs_dx_next;
            abs_dy_reg    <= abs_dy_next;
            col_dir_reg   <= col_dir_next;
            row_dir_reg   <= row_dir_next;
            major_reg     <= major_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_x     = out_x_reg;
    assign pixels.pixel_y     = out_y_reg;
    assign pixels.pixel_color = out_color_reg;
    assign pixels.last        = out_last_reg;

endmodule

// ----- hdl/lpr_checker.sv -----
// ----------------------------------------------------------------------------
// lpr_checker: port-level checks of the line pixel rasterizer
// Watches the top-level channels over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module lpr_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // A pixel waiting on a stalled receiver stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel dropped while the receiver stalled");

    // Commands are refused only while the result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("command channel blocked without an output stall");

    // A new pixel is offered only once its accepted command has passed the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("pixel appeared with no command behind it");

    // Leaving reset, no pixel is offered.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("pixel offered right after reset");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmds.valid),
    .in_ready  (cmds.ready),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready)
);
